// ===== rtl/core/swrr_pkg.sv =====
package swrr_pkg;

    // Fixed field widths of the request, result and configuration channels.
    localparam int unsigned WEIGHT_W   = 7;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned CHOSEN_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned URG_W      = 32;

    // Request actions.
    localparam logic ACT_PICK  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Saturation limits of an urgency value.
    localparam logic signed [URG_W-1:0] URG_MAX = {1'b0, {(URG_W-1){1'b1}}};
    localparam logic signed [URG_W-1:0] URG_MIN = {1'b1, {(URG_W-1){1'b0}}};

    typedef struct packed {
        logic              action;
        logic [MASK_W-1:0] usable_mask;
    } pick_t;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic                found;
    } result_t;

    // Clamp a value one bit wider than an urgency to the signed urgency range.
    function automatic logic signed [URG_W-1:0] sat_urg(input logic [URG_W:0] v);
        logic signed [URG_W-1:0] r;
        case (v[URG_W:URG_W-1])
            2'b01:   r = URG_MAX;
            2'b10:   r = URG_MIN;
            default: r = v[URG_W-1:0];
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/smooth_weighted_round_robin_unit.sv =====
// Smooth weighted round-robin selector.
//
// Channels: the pick channel (pick_valid, pick_ready, pick) carries one request,
// either a pick with a mask of usable workers or a clear of all urgency values.
// The result channel (result_valid, result_ready, result) returns exactly one
// result per request: the chosen worker and a found flag. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes per-worker weights
// and is always ready; the user must write it only while idle (not enforced).
//
// Timing: a pick request walks the workers through one shared saturating adder
// and comparator, one worker per cycle, then applies the subtraction to the
// winner in the apply state, where its result is written to the output register.
// A new request can be taken in the apply state once the output slot is free,
// so the next request is accepted while the current one is being applied.
// A clear request zeroes all urgency values when it is accepted and goes straight
// to the apply state. The scan over the workers sets the pace of pick requests.
//
// Reset clears all urgency values, sets every weight to one and empties the
// result register. When the receiver stalls, the result waits in the output
// register and the sequencer holds in its apply state until the slot frees up.
module smooth_weighted_round_robin_unit #(
    parameter int unsigned WORKERS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pick_valid,
    output logic                              pick_ready,
    input  swrr_pkg::pick_t                   pick,
    output logic                              result_valid,
    input  logic                              result_ready,
    output swrr_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrr_pkg::WEIGHT_W-1:0]     cfg_data
);

    localparam int unsigned IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    // Width of the sum of all weights added in one pick.
    localparam int unsigned TOT_W = swrr_pkg::WEIGHT_W + IDX_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [WORKERS-1:0]                 mask_reg, mask_next;
    logic [TOT_W-1:0]                   total_reg, total_next;
    logic                               have_reg, have_next;
    logic [IDX_W-1:0]                   best_reg, best_next;
    logic signed [swrr_pkg::URG_W-1:0]  best_val_reg, best_val_next;
    logic signed [swrr_pkg::URG_W-1:0]  urg_reg  [WORKERS];
    logic signed [swrr_pkg::URG_W-1:0]  urg_next [WORKERS];
    logic [swrr_pkg::WEIGHT_W-1:0]      weight_reg [WORKERS];
    logic                               out_valid_reg, out_valid_next;
    swrr_pkg::result_t                  out_reg, out_next;

    logic                               slot_free;
    logic                               accept;
    logic signed [swrr_pkg::URG_W-1:0]  cur_urg;
    logic [swrr_pkg::WEIGHT_W-1:0]      cur_weight;
    logic signed [swrr_pkg::URG_W-1:0]  added;
    logic signed [swrr_pkg::URG_W-1:0]  reduced;

    assign slot_free    = !out_valid_reg || result_ready;
    assign pick_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_APPLY) && slot_free);
    assign accept       = pick_valid && pick_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Shared saturating adder; its sum feeds the comparator.
    assign cur_urg    = urg_reg[idx_reg];
    assign cur_weight = weight_reg[idx_reg];
    assign added      = swrr_pkg::sat_urg({cur_urg[swrr_pkg::URG_W-1], cur_urg}
                                          + (swrr_pkg::URG_W + 1)'(cur_weight));
    assign reduced    = swrr_pkg::sat_urg({best_val_reg[swrr_pkg::URG_W-1], best_val_reg}
                                          - (swrr_pkg::URG_W + 1)'(total_reg));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        total_next     = total_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        for (int i = 0; i < WORKERS; i++)
        begin
            urg_next[i] = urg_reg[i];
        end

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                if (mask_reg[idx_reg])
                begin
                    urg_next[idx_reg] = added;
                    total_next        = total_reg + TOT_W'(cur_weight);
                    // Strictly greater keeps the lowest index on a tie.
                    if (!have_reg || (added > best_val_reg))
                    begin
                        have_next     = 1'b1;
                        best_next     = idx_reg;
                        best_val_next = added;
                    end
                end
                if (idx_reg == IDX_W'(WORKERS - 1))
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    if (have_reg)
                    begin
                        urg_next[best_reg] = reduced;
                    end
                    out_valid_next = 1'b1;
                    out_next.chosen = have_reg ? swrr_pkg::CHOSEN_W'(best_reg) : '0;
                    out_next.found  = have_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new request starts here; a clear wins over a pending write-back.
        if (accept)
        begin
            idx_next   = '0;
            total_next = '0;
            have_next  = 1'b0;
            best_next  = '0;
            mask_next  = pick.usable_mask[WORKERS-1:0];
            if (pick.action == swrr_pkg::ACT_CLEAR)
            begin
                for (int i = 0; i < WORKERS; i++)
                begin
                    urg_next[i] = '0;
                end
                state_next = ST_APPLY;
            end
            else
            begin
                state_next = ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WORKERS; i++)
            begin
                urg_reg[i]    <= '0;
                weight_reg[i] <= swrr_pkg::WEIGHT_W'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            have_reg      <= have_next;
            best_reg      <= best_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < WORKERS; i++)
            begin
                urg_reg[i] <= urg_next[i];
            end
            // Writes to a weight of a worker that does not exist are dropped.
            if (cfg_valid && (32'(cfg_index) < WORKERS))
            begin
                weight_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        best_val_reg <= best_val_next;
        out_reg      <= out_next;
    end

endmodule

// ===== tb/tb_smooth_weighted_round_robin_unit.sv =====
`timescale 1ns / 1ps

module tb_smooth_weighted_round_robin_unit;

    // The block is built with its full complement of workers.
    localparam int WORKERS         = 8;
    localparam int CLK_HIGH        = 4;
    localparam int CLK_LOW         = 4;
    localparam int RESET_CYCLES    = 5;
    localparam int PHASES          = 8;
    localparam int REQS_PER_PHASE  = 241;
    localparam int LONG_HOLD       = 150;
    localparam int MAX_GAP         = 24;
    localparam int SETTLE_CYCLES   = WORKERS + 4;
    localparam int MAX_REPORTS     = 30;
    localparam int DIRECTED_ROWS   = 24;

    // One row of the directed table. Where typed is set, the expected result
    // is the one written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic                          action;
        logic [swrr_pkg::MASK_W-1:0]   usable_mask;
        logic                          typed;
        logic [swrr_pkg::CHOSEN_W-1:0] chosen;
        logic                          found;
    } directed_row_t;

    // The directed rows run with the weights at their reset value of one, so
    // a pick over a fresh or cleared set of workers ends in a tie that the
    // lowest index wins, and a single usable worker is always the one chosen.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{swrr_pkg::ACT_CLEAR, 8'h00, 1'b1, 3'd0, 1'b0},  // clear straight after reset
        '{swrr_pkg::ACT_PICK,  8'h00, 1'b1, 3'd0, 1'b0},  // nobody usable
        '{swrr_pkg::ACT_PICK,  8'hFF, 1'b1, 3'd0, 1'b0 | 1'b1},  // full tie, lowest wins
        '{swrr_pkg::ACT_PICK,  8'hFF, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'h80, 1'b1, 3'd7, 1'b1},  // top worker alone
        '{swrr_pkg::ACT_PICK,  8'h01, 1'b1, 3'd0, 1'b1},  // bottom worker alone
        '{swrr_pkg::ACT_PICK,  8'h55, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'hAA, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_CLEAR, 8'hFF, 1'b1, 3'd0, 1'b0},  // the mask means nothing on a clear
        '{swrr_pkg::ACT_PICK,  8'h00, 1'b1, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'h02, 1'b1, 3'd1, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'h04, 1'b1, 3'd2, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'h08, 1'b1, 3'd3, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'h10, 1'b1, 3'd4, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'h20, 1'b1, 3'd5, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'h40, 1'b1, 3'd6, 1'b1},
        '{swrr_pkg::ACT_PICK,  8'hFF, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'hFF, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'h0F, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'hF0, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'hC3, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'h3C, 1'b0, 3'd0, 1'b0},
        '{swrr_pkg::ACT_CLEAR, 8'h00, 1'b1, 3'd0, 1'b0},
        '{swrr_pkg::ACT_PICK,  8'hFF, 1'b1, 3'd0, 1'b1}   // every urgency is equal again
    };

    // Clock, reset and every input of the block start at known values.
    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            pick_valid   = 1'b0;
    logic                            pick_ready;
    swrr_pkg::pick_t                 pick         = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    swrr_pkg::result_t               result;
    logic                            cfg_valid    = 1'b0;
    logic                            cfg_ready;
    logic [swrr_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [swrr_pkg::WEIGHT_W-1:0]   cfg_data     = '0;

    // Our own copy of the scheduler state: weights and urgency values.
    logic [swrr_pkg::WEIGHT_W-1:0]   weight_copy [WORKERS];
    int                              urgency_copy [WORKERS];

    // Expected results, oldest first, in the order the requests were taken.
    swrr_pkg::result_t               pending_choices [$];

    // Idling knobs set by the stimulus process and read by the drivers.
    int                    sender_idle_pct = 0;
    int                    receiver_stall_pct = 0;

    // A long hold-off on the result side is asked for by bumping
    // hold_asked; the receiver process starts it and counts it down itself.
    int                    hold_asked = 0;
    int                    hold_taken = 0;
    int                    hold_left  = 0;

    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    requests_sent = 0;
    int                    clears_sent = 0;
    int                    picks_found = 0;

    smooth_weighted_round_robin_unit #(
        .WORKERS (WORKERS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pick_valid   (pick_valid),
        .pick_ready   (pick_ready),
        .pick         (pick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // Clamp a wide sum back into the signed 32-bit urgency range.
    function automatic int clamp_urgency(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(64'h8000_0000))
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Apply one request to the state copy and return the result it yields.
    // A clear zeroes every urgency. A pick raises each usable worker by its
    // weight, takes the largest urgency (lowest index on a tie) and lowers
    // the winner by the total that was added.
    function automatic swrr_pkg::result_t choose_worker(input swrr_pkg::pick_t req);
        swrr_pkg::result_t outcome;
        longint            added;
        bit                any_usable;
        int                best;
        outcome    = '0;
        added      = 0;
        any_usable = 1'b0;
        best       = 0;
        if (req.action == swrr_pkg::ACT_CLEAR)
        begin
            for (int i = 0; i < WORKERS; i++)
                urgency_copy[i] = 0;
            return outcome;
        end
        for (int i = 0; i < WORKERS; i++)
        begin
            if (req.usable_mask[i])
            begin
                urgency_copy[i] = clamp_urgency(longint'(urgency_copy[i])
                                                + longint'(weight_copy[i]));
                added += longint'(weight_copy[i]);
                if (!any_usable || urgency_copy[i] > urgency_copy[best])
                begin
                    best       = i;
                    any_usable = 1'b1;
                end
            end
        end
        if (any_usable)
        begin
            urgency_copy[best] = clamp_urgency(longint'(urgency_copy[best]) - added);
            outcome.chosen     = best[swrr_pkg::CHOSEN_W-1:0];
            outcome.found      = 1'b1;
        end
        return outcome;
    endfunction

    // Result side. Every accepted result is compared with the oldest
    // expectation. The ready line is then chosen for the next cycle: either
    // a long hold-off in progress, or a random stall at the current rate.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (pending_choices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result chosen=%0d found=%0b %s",
                                 $time, result.chosen, result.found,
                                 "arrived with no request waiting");
                end
                else
                begin
                    swrr_pkg::result_t want;
                    want = pending_choices.pop_front();
                    if (want.found)
                        picks_found++;
                    if (result.chosen !== want.chosen || result.found !== want.found)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected chosen=%0d found=%0b, %s=%0d found=%0b",
                                     $time, want.chosen, want.found, "actual chosen",
                                     result.chosen, result.found);
                    end
                end
            end

            if (hold_taken != hold_asked)
            begin
                hold_taken   <= hold_asked;
                hold_left    <= LONG_HOLD;
                result_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Offer one request, idling first at the current rate. The predictor runs
    // at the accepting edge; rows with a typed result queue that instead.
    task automatic offer_request(input swrr_pkg::pick_t req, input bit typed,
                                 input swrr_pkg::result_t typed_want);
        int                gap;
        swrr_pkg::result_t predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pick_valid <= 1'b1;
        pick       <= req;
        @(posedge clk);
        while (!pick_ready)
            @(posedge clk);
        predicted = choose_worker(req);
        pending_choices.push_back(typed ? typed_want : predicted);
        requests_sent++;
        if (req.action == swrr_pkg::ACT_CLEAR)
            clears_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken.
    // At least one edge passes, so the valid line is never lowered and raised
    // in the same step.
    task automatic drain_results();
        pick_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_choices.size() != 0);
    endtask

    // Write all eight weight registers back to back; only called while the
    // block is idle. The copy is updated at each accepting edge.
    task automatic program_weights(input logic [swrr_pkg::WEIGHT_W-1:0] values [WORKERS]);
        for (int i = 0; i < WORKERS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[swrr_pkg::CFG_IDX_W-1:0];
            cfg_data  <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            weight_copy[i] = values[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Main stimulus: directed table, then eight phases that each load a new
    // weight setting and run random requests under one idling pattern.
    initial
    begin
        logic [swrr_pkg::WEIGHT_W-1:0] setting [WORKERS];
        directed_row_t                 row;
        swrr_pkg::pick_t               req;
        swrr_pkg::result_t             typed_want;
        int                            roll;
        int                            favored;

        for (int i = 0; i < WORKERS; i++)
        begin
            weight_copy[i]  = swrr_pkg::WEIGHT_W'(1);
            urgency_copy[i] = 0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row                 = DIRECTED[r];
            req.action          = row.action;
            req.usable_mask     = row.usable_mask;
            typed_want.chosen   = row.chosen;
            typed_want.found    = row.found;
            offer_request(req, row.typed, typed_want);
        end
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Weight settings cover both ends of the register: all zero, all
            // one, the largest stated weight, the all-ones code, and mixes.
            favored = $urandom_range(0, WORKERS - 1);
            for (int i = 0; i < WORKERS; i++)
            begin
                case (phase)
                    1:       setting[i] = 7'd100;
                    2:       setting[i] = 7'd0;
                    3:       setting[i] = 7'd127;
                    4:       setting[i] = 7'd1;
                    5:       setting[i] = swrr_pkg::WEIGHT_W'($urandom_range(0, 127));
                    6:       setting[i] = (i == favored) ? 7'd100 : 7'd1;
                    default: setting[i] = swrr_pkg::WEIGHT_W'($urandom_range(1, 100));
                endcase
            end
            program_weights(setting);

            // Idling pattern: none, sender gaps, receiver stalls, light both.
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 9;  receiver_stall_pct = 9;  end
            endcase

            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                // With the sender offering back to back, a long hold-off on
                // the result side fills the block and stalls its input.
                if ((phase % 4) == 0 && n == REQS_PER_PHASE / 4)
                    hold_asked++;
                // Once, halfway through phase two, the sender waits for the block to empty.
                if (phase == 2 && n == REQS_PER_PHASE / 2)
                    drain_results();

                // Mostly picks over varied masks: full sets to build up the
                // smooth schedule, single workers, random subsets, the odd
                // empty mask and an occasional clear with a random mask.
                roll            = $urandom_range(0, 99);
                req.action      = swrr_pkg::ACT_PICK;
                req.usable_mask = swrr_pkg::MASK_W'($urandom_range(0, 255));
                if (roll < 3)
                    req.action = swrr_pkg::ACT_CLEAR;
                else if (roll < 6)
                    req.usable_mask = '0;
                else if (roll < 35)
                    req.usable_mask = '1;
                else if (roll < 45)
                    req.usable_mask = 8'h01 << $urandom_range(0, WORKERS - 1);
                offer_request(req, 1'b0, '0);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d clears), %0d results, %0d with a worker found,",
                 requests_sent, clears_sent, results_seen, picks_found);
        $display("over %0d weight settings including all-zero, all-one and all-ones weights.",
                 PHASES + 1);
        if (mismatches == 0 && pending_choices.size() == 0)
            $display("smooth_weighted_round_robin_unit regression: pass");
        else
            $display("smooth_weighted_round_robin_unit regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("%0t: run did not finish, %0d results still expected",
                 $time, pending_choices.size());
        $display("smooth_weighted_round_robin_unit regression: fail");
        $finish;
    end

endmodule
